FILE: sv/tsc_pkg.sv
// Shared types, constants and helpers for the touch sample calibrator.
// No dependencies; used by every other file of the block.
package tsc_pkg;

  localparam int unsigned SAMP_W    = 12;
  localparam int unsigned RAW_W     = 13;
  localparam int unsigned PROD_W    = 25;
  localparam int unsigned DVD_W     = 26;
  localparam int unsigned DVS_W     = 13;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DIV_STEPS = 12;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [RAW_W-1:0]  Z_TOUCH   = 13'd300;
  localparam logic [RAW_W-1:0]  Z_RELEASE = 13'd75;
  localparam logic [31:0]       WAIT_MS   = 32'd3;
  localparam logic [SAMP_W-1:0] FULL      = 12'd4095;

  typedef logic [DIV_CNT_W-1:0] div_cnt_t;

  typedef enum logic [2:0] {
    REG_ROTATION,
    REG_HORIZ_MIN,
    REG_HORIZ_MAX,
    REG_VERT_MIN,
    REG_VERT_MAX,
    REG_HORIZ_RES,
    REG_VERT_RES,
    REG_AXIS_SWAP
  } reg_idx_t;

  typedef enum logic [1:0] {
    ROT_0,
    ROT_1,
    ROT_2,
    ROT_3
  } rot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_WAIT,
    S_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        rotation;
    logic [SAMP_W-1:0] horiz_min;
    logic [SAMP_W-1:0] horiz_max;
    logic [SAMP_W-1:0] vert_min;
    logic [SAMP_W-1:0] vert_max;
    logic [SAMP_W-1:0] horiz_res;
    logic [SAMP_W-1:0] vert_res;
    logic              axis_swap;
  } cfg_t;

  function automatic logic [SAMP_W-1:0] absdiff(input logic [SAMP_W-1:0] a,
                                                input logic [SAMP_W-1:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction

  // Mean of the closest pair of three samples; ties prefer (a,b), then (a,c).
  function automatic logic [SAMP_W-1:0] closest_mean(input logic [SAMP_W-1:0] a,
                                                     input logic [SAMP_W-1:0] b,
                                                     input logic [SAMP_W-1:0] c);
    logic [SAMP_W-1:0] dab;
    logic [SAMP_W-1:0] dac;
    logic [SAMP_W-1:0] dcb;
    logic [SAMP_W:0]   sum;
    dab = absdiff(a, b);
    dac = absdiff(a, c);
    dcb = absdiff(c, b);
    if (dab <= dac && dab <= dcb) begin
      sum = {1'b0, a} + {1'b0, b};
    end else if (dac <= dab && dac <= dcb) begin
      sum = {1'b0, a} + {1'b0, c};
    end else begin
      sum = {1'b0, b} + {1'b0, c};
    end
    closest_mean = sum[SAMP_W:1];
  endfunction

endpackage

FILE: sv/tsc_cfg.sv
// Configuration register file with its APB-style access port.
// Depends on tsc_pkg for the register layout.
module tsc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output tsc_pkg::cfg_t               cfg
);

  tsc_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = tsc_pkg::reg_idx_t'(paddr[tsc_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation  <= 2'd1;
      cfg.horiz_min <= '0;
      cfg.horiz_max <= tsc_pkg::FULL;
      cfg.vert_min  <= '0;
      cfg.vert_max  <= tsc_pkg::FULL;
      cfg.horiz_res <= 12'd320;
      cfg.vert_res  <= 12'd240;
      cfg.axis_swap <= 1'b0;
    end else if (wr) begin
      case (idx)
        tsc_pkg::REG_ROTATION:  cfg.rotation  <= pwdata[1:0];
        tsc_pkg::REG_HORIZ_MIN: cfg.horiz_min <= pwdata[tsc_pkg::SAMP_W-1:0];
        tsc_pkg::REG_HORIZ_MAX: cfg.horiz_max <= pwdata[tsc_pkg::SAMP_W-1:0];
        tsc_pkg::REG_VERT_MIN:  cfg.vert_min  <= pwdata[tsc_pkg::SAMP_W-1:0];
        tsc_pkg::REG_VERT_MAX:  cfg.vert_max  <= pwdata[tsc_pkg::SAMP_W-1:0];
        tsc_pkg::REG_HORIZ_RES: cfg.horiz_res <= pwdata[tsc_pkg::SAMP_W-1:0];
        tsc_pkg::REG_VERT_RES:  cfg.vert_res  <= pwdata[tsc_pkg::SAMP_W-1:0];
        tsc_pkg::REG_AXIS_SWAP: cfg.axis_swap <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tsc_pkg::REG_ROTATION:  prdata = {30'd0, cfg.rotation};
      tsc_pkg::REG_HORIZ_MIN: prdata = {20'd0, cfg.horiz_min};
      tsc_pkg::REG_HORIZ_MAX: prdata = {20'd0, cfg.horiz_max};
      tsc_pkg::REG_VERT_MIN:  prdata = {20'd0, cfg.vert_min};
      tsc_pkg::REG_VERT_MAX:  prdata = {20'd0, cfg.vert_max};
      tsc_pkg::REG_HORIZ_RES: prdata = {20'd0, cfg.horiz_res};
      tsc_pkg::REG_VERT_RES:  prdata = {20'd0, cfg.vert_res};
      tsc_pkg::REG_AXIS_SWAP: prdata = {31'd0, cfg.axis_swap};
      default:                prdata = '0;
    endcase
  end

endmodule

FILE: sv/tsc_div.sv
// Shared restoring divider: one quotient bit a cycle, quotient overflow flag.
// Depends on tsc_pkg for widths and step count.
module tsc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tsc_pkg::DVD_W-1:0]   dividend,
  input  logic [tsc_pkg::DVS_W-1:0]   divisor,
  output logic                        busy,
  output logic                        ovf,
  output logic [tsc_pkg::SAMP_W-1:0]  quot
);

  localparam int unsigned LOW_W = tsc_pkg::SAMP_W;

  logic [tsc_pkg::DVS_W-1:0] dvs;
  logic [tsc_pkg::DVS_W-1:0] rem;
  logic [tsc_pkg::DVS_W:0]   trial;
  logic                      ge;
  tsc_pkg::div_cnt_t         cnt;

  assign trial = {rem, quot[LOW_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= tsc_pkg::div_cnt_t'(tsc_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= cnt != tsc_pkg::div_cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs  <= divisor;
      ovf  <= dividend >= {divisor, {LOW_W{1'b0}}};
      rem  <= dividend[tsc_pkg::DVS_W+LOW_W-1:LOW_W];
      quot <= dividend[LOW_W-1:0];
    end else if (busy) begin
      rem  <= ge ? tsc_pkg::DVS_W'(trial - {1'b0, dvs}) : trial[tsc_pkg::DVS_W-1:0];
      quot <= {quot[LOW_W-2:0], ge};
    end
  end

endmodule

FILE: sv/touch_sample_calibrator.sv
// Touch sample calibrator: conditions resistive touch frames into held raw and
// calibrated coordinates. The block takes one item at a time. A pen event, a
// gated frame or a low-pressure frame goes from the evaluate state straight to
// the done state. A full frame passes the multiply, divide, wait and finish
// states once per axis before the done state, using one shared 12-step divider
// after each multiply. A result waits in the output register while the
// receiver stalls. The next item is taken once the result has moved there.
// Depends on tsc_pkg, tsc_cfg and tsc_div.
module touch_sample_calibrator #(
  parameter bit HAS_PEN_IRQ = 1'b1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [31:0]                 now_ms,
  input  logic [11:0]                 press_a,
  input  logic [11:0]                 press_b,
  input  logic [11:0]                 samp0,
  input  logic [11:0]                 samp1,
  input  logic [11:0]                 samp2,
  input  logic [11:0]                 samp3,
  input  logic [11:0]                 samp4,
  input  logic [11:0]                 samp5,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        touched,
  output logic                        skipped,
  output logic                        pen_wake,
  output logic [12:0]                 pos_x_raw,
  output logic [12:0]                 pos_y_raw,
  output logic [12:0]                 pressure,
  output logic [11:0]                 pos_x_cal,
  output logic [11:0]                 pos_y_cal
);

  localparam int unsigned SW = tsc_pkg::SAMP_W;
  localparam int unsigned RW = tsc_pkg::RAW_W;

  tsc_pkg::cfg_t   cfg;
  tsc_pkg::state_t state;
  tsc_pkg::state_t state_next;

  logic          req_q;
  logic [31:0]   now_q;
  logic [SW-1:0] za_q;
  logic [SW-1:0] zb_q;
  logic [SW-1:0] s_q [6];

  logic          wake;
  logic [31:0]   last_good;
  logic [RW-1:0] hx_raw;
  logic [RW-1:0] hy_raw;
  logic [RW-1:0] hpress;
  logic [SW-1:0] hx_cal;
  logic [SW-1:0] hy_cal;
  logic          skip;
  logic          sw;
  logic          ax;

  logic [tsc_pkg::PROD_W-1:0] prod;
  logic          neg_q;
  logic          rev_q;
  logic          eq_q;
  logic [SW-1:0] res_q;
  logic [SW-1:0] den_q;

  logic          div_start;
  logic          div_busy;
  logic          div_ovf;
  logic [SW-1:0] div_quot;

  logic          gate;
  logic [RW-1:0] z;
  logic [SW-1:0] mx;
  logic [SW-1:0] my;
  logic [RW-1:0] xr;
  logic [RW-1:0] yr;
  logic [SW-1:0] hmax;
  logic [SW-1:0] vmax;

  logic          use_h;
  logic [RW-1:0] raw;
  logic [SW-1:0] ca;
  logic [SW-1:0] cb;
  logic [SW-1:0] cres;
  logic          rev;
  logic [SW-1:0] lo;
  logic [SW-1:0] hi;
  logic          neg;
  logic [RW-1:0] mag;

  logic          big;
  logic [SW-1:0] cval;
  logic          out_load;

  tsc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({prod, 1'b0} + tsc_pkg::DVD_W'(den_q)),
    .divisor  ({den_q, 1'b0}),
    .busy     (div_busy),
    .ovf      (div_ovf),
    .quot     (div_quot)
  );

  // Frame evaluation
  assign gate = wake && ((now_q - last_good) >= tsc_pkg::WAIT_MS);
  assign z    = {1'b0, za_q} + {1'b0, tsc_pkg::FULL} - {1'b0, zb_q};
  assign mx   = tsc_pkg::closest_mean(s_q[0], s_q[2], s_q[4]);
  assign my   = tsc_pkg::closest_mean(s_q[1], s_q[3], s_q[5]);
  assign hmax = (cfg.horiz_min < cfg.horiz_max) ? cfg.horiz_max : cfg.horiz_min;
  assign vmax = (cfg.vert_min < cfg.vert_max) ? cfg.vert_max : cfg.vert_min;

  always_comb begin
    case (tsc_pkg::rot_t'(cfg.rotation))
      tsc_pkg::ROT_0: begin
        xr = {1'b0, tsc_pkg::FULL - my};
        yr = {1'b0, mx};
      end
      tsc_pkg::ROT_1: begin
        xr = {1'b0, mx};
        yr = {1'b0, my};
      end
      tsc_pkg::ROT_2: begin
        xr = {1'b0, my};
        yr = {tsc_pkg::FULL, 1'b0} - {1'b0, mx} - {1'b0, vmax};
      end
      default: begin
        xr = {tsc_pkg::FULL, 1'b0} - {1'b0, mx} - {1'b0, hmax};
        yr = {1'b0, tsc_pkg::FULL - my};
      end
    endcase
  end

  // Per-axis scaling operands
  assign use_h = ax ? sw : !sw;
  assign raw   = ax ? hy_raw : hx_raw;
  assign ca    = use_h ? cfg.horiz_min : cfg.vert_min;
  assign cb    = use_h ? cfg.horiz_max : cfg.vert_max;
  assign cres  = use_h ? cfg.horiz_res : cfg.vert_res;
  assign rev   = ca > cb;
  assign lo    = rev ? cb : ca;
  assign hi    = rev ? ca : cb;
  assign neg   = raw < {1'b0, lo};
  assign mag   = neg ? {1'b0, lo} - raw : raw - {1'b0, lo};

  // Rounded quotient to pixel, with reversal and clamping
  assign big = div_ovf || (div_quot > res_q);
  always_comb begin
    if (eq_q) begin
      cval = '0;
    end else if (!rev_q) begin
      cval = neg_q ? '0 : (big ? res_q : div_quot);
    end else begin
      cval = neg_q ? res_q : (big ? '0 : res_q - div_quot);
    end
  end

  assign in_stall  = state != tsc_pkg::S_IDLE;
  assign div_start = state == tsc_pkg::S_DIV;
  assign out_load  = (state == tsc_pkg::S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tsc_pkg::S_IDLE: begin
        if (in_valid) state_next = tsc_pkg::S_EVAL;
      end
      tsc_pkg::S_EVAL: begin
        if (req_q && gate && z >= tsc_pkg::Z_TOUCH) state_next = tsc_pkg::S_MUL;
        else state_next = tsc_pkg::S_DONE;
      end
      tsc_pkg::S_MUL:  state_next = tsc_pkg::S_DIV;
      tsc_pkg::S_DIV:  state_next = tsc_pkg::S_WAIT;
      tsc_pkg::S_WAIT: begin
        if (!div_busy) state_next = tsc_pkg::S_FIN;
      end
      tsc_pkg::S_FIN: begin
        state_next = ax ? tsc_pkg::S_DONE : tsc_pkg::S_MUL;
      end
      tsc_pkg::S_DONE: begin
        if (out_load) state_next = tsc_pkg::S_IDLE;
      end
      default: state_next = tsc_pkg::S_IDLE;
    endcase
  end

  // Input capture and scaling operands
  always_ff @(posedge clk) begin
    if (state == tsc_pkg::S_IDLE && in_valid) begin
      req_q  <= req_type;
      now_q  <= now_ms;
      za_q   <= press_a;
      zb_q   <= press_b;
      s_q[0] <= samp0;
      s_q[1] <= samp1;
      s_q[2] <= samp2;
      s_q[3] <= samp3;
      s_q[4] <= samp4;
      s_q[5] <= samp5;
    end
    if (state == tsc_pkg::S_MUL) begin
      prod  <= tsc_pkg::PROD_W'(mag) * tsc_pkg::PROD_W'(cres);
      neg_q <= neg;
      rev_q <= rev;
      eq_q  <= lo == hi;
      res_q <= cres;
      den_q <= hi - lo;
    end
  end

  // Held state
  always_ff @(posedge clk) begin
    if (rst) begin
      wake      <= 1'b1;
      last_good <= '0;
      hx_raw    <= '0;
      hy_raw    <= '0;
      hpress    <= '0;
      hx_cal    <= '0;
      hy_cal    <= '0;
      skip      <= 1'b1;
      sw        <= 1'b0;
      ax        <= 1'b0;
    end else begin
      case (state)
        tsc_pkg::S_EVAL: begin
          skip <= 1'b1;
          ax   <= 1'b0;
          if (!req_q) begin
            if (HAS_PEN_IRQ) wake <= 1'b1;
          end else if (gate) begin
            skip <= 1'b0;
            if (z < tsc_pkg::Z_TOUCH) begin
              hpress <= '0;
              if (HAS_PEN_IRQ && z < tsc_pkg::Z_RELEASE) wake <= 1'b0;
            end else begin
              hpress    <= z;
              last_good <= now_q;
              hx_raw    <= xr;
              hy_raw    <= yr;
              sw        <= cfg.axis_swap ^ !cfg.rotation[0];
            end
          end
        end
        tsc_pkg::S_FIN: begin
          if (ax) hy_cal <= cval;
          else hx_cal <= cval;
          ax <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      touched   <= hpress >= tsc_pkg::Z_TOUCH;
      skipped   <= skip;
      pen_wake  <= wake;
      pos_x_raw <= hx_raw;
      pos_y_raw <= hy_raw;
      pressure  <= hpress;
      pos_x_cal <= hx_cal;
      pos_y_cal <= hy_cal;
    end
  end

endmodule
